// ===== rtl/vpd_pkg.sv =====
// Shared types and constants of the palette DAC register front end.
package vpd_pkg;

  typedef enum logic [1:0] {
    PORT_MASK       = 2'd0,
    PORT_READ_ADDR  = 2'd1,
    PORT_WRITE_ADDR = 2'd2,
    PORT_DATA       = 2'd3
  } port_t;

  localparam logic ACT_READ  = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

  localparam logic [2:0] REG_EIGHT_BIT     = 3'd0;
  localparam logic [2:0] REG_HIDDEN_ENABLE = 3'd1;
  localparam logic [2:0] REG_FULL_LOAD     = 3'd2;
  localparam logic [2:0] REG_SHARED_INDEX  = 3'd3;
  localparam logic [2:0] REG_VGA_CLASS     = 3'd4;
  localparam logic [2:0] REG_LATCHED       = 3'd5;

  localparam logic [1:0] PHASE_RED   = 2'd0;
  localparam logic [1:0] PHASE_GREEN = 2'd1;
  localparam logic [1:0] PHASE_BLUE  = 2'd2;
  localparam logic [1:0] PHASE_NONE  = 2'd3;

  localparam int unsigned NUM_COMP      = 3;
  localparam int unsigned PALETTE_DEPTH = 256;

  localparam logic [7:0] COMP_MASK_6BIT   = 8'h3f;
  localparam logic [7:0] STATUS_READ_MODE = 8'h03;
  localparam logic [2:0] UNLOCK_COUNT     = 3'd4;

  typedef struct packed {
    logic accept;
    logic load_direct;
    logic load_mem;
  } vpd_cmd_t;

  typedef struct packed {
    logic data_read;
  } vpd_status_t;

endpackage

// ===== rtl/vga_palette_dac_ports.sv =====
// Top level of the palette DAC register front end.
//
// Channel  Direction  Handshake              Word
// in       input      in_valid / in_ready    action, port_select, write_data
// out      output     out_valid / out_ready  read_data, palette_changed,
//                                            hidden_written, hidden_value
// cfg      input      cfg_write              cfg_index, cfg_data
//
// A word to any port but a data read loads its result straight into the output
// register; a data read waits in a read state for the registered palette read.
// The output register lets a new word enter in the cycle its result is taken.
// Reset initialises all control state and clears the per-entry valid bits, so unwritten
// palette entries read as zero without a clearing pass.
// A stalled output holds the input channel until the result is taken.
module vga_palette_dac_ports
  import vpd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [2:0] cfg_index,
  input  logic       cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       action,
  input  logic [1:0] port_select,
  input  logic [7:0] write_data,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] read_data,
  output logic       palette_changed,
  output logic       hidden_written,
  output logic [7:0] hidden_value
);

  vpd_cmd_t    cmd;
  vpd_status_t status;

  vpd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status   (status),
    .cmd      (cmd)
  );

  vpd_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .action         (action),
    .port_select    (port_select),
    .write_data     (write_data),
    .read_data      (read_data),
    .palette_changed(palette_changed),
    .hidden_written (hidden_written),
    .hidden_value   (hidden_value)
  );

  a_data_read_waits: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (action == ACT_READ) && (port_select == PORT_DATA)
    |=> !in_ready)
    else $error("input taken during palette read wait");

  a_ready_needs_room: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> (!out_valid || out_ready))
    else $error("input ready while output register is blocked");

  a_hidden_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid && hidden_written |-> !palette_changed && (read_data == 8'd0))
    else $error("hidden register write carries other result flags");

endmodule

// ===== rtl/vpd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module vpd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/vpd_ctrl.sv =====
// Controller that sequences bus words and the palette read wait.
module vpd_ctrl
  import vpd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  vpd_status_t status,
  output vpd_cmd_t    cmd
);

  typedef enum logic {
    S_IDLE,
    S_MEMRD
  } state_t;

  state_t state;
  logic   out_free;

  always_comb begin
    out_free        = !out_valid || out_ready;
    in_ready        = (state == S_IDLE) && out_free;
    cmd.accept      = in_valid && in_ready;
    cmd.load_direct = cmd.accept && !status.data_read;
    cmd.load_mem    = (state == S_MEMRD) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd.accept && status.data_read) begin
            state <= S_MEMRD;
          end
        end
        S_MEMRD: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (cmd.load_direct || cmd.load_mem) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/vpd_datapath.sv =====
// Datapath with the port registers, staged components and palette memories.
module vpd_datapath
  import vpd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  vpd_cmd_t    cmd,
  output vpd_status_t status,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic        cfg_data,
  input  logic        action,
  input  logic [1:0]  port_select,
  input  logic [7:0]  write_data,
  output logic [7:0]  read_data,
  output logic        palette_changed,
  output logic        hidden_written,
  output logic [7:0]  hidden_value
);

  logic eight_bit_mode, hidden_reg_enable, full_load_update;
  logic shared_index_variant, vga_class, latched_colour_mode;

  logic [7:0] staged [NUM_COMP];
  logic [7:0] staged_next [NUM_COMP];
  logic [1:0] phase, phase_next;
  logic [7:0] read_address, read_address_next;
  logic [7:0] write_address, write_address_next;
  logic       in_read_mode, in_read_mode_next;
  logic [7:0] pixel_mask, pixel_mask_next;
  logic [2:0] mask_count, mask_count_next;
  logic [7:0] hidden_control, hidden_control_next;
  logic [1:0] rd_phase, rd_phase_next;
  logic       rd_ok, rd_ok_next;
  logic [PALETTE_DEPTH-1:0] entry_valid;
  logic       valid_set;

  logic [NUM_COMP-1:0] ram_we;
  logic [7:0] ram_wdata [NUM_COMP];
  logic [7:0] ram_q [NUM_COMP];
  logic       ram_re;

  logic [7:0] data_m;
  logic [7:0] rd_val;
  logic [7:0] mem_val;
  logic       changed, hid, wrote;

  assign status.data_read = (action == ACT_READ) && (port_t'(port_select) == PORT_DATA);
  assign hidden_value     = hidden_control;

  for (genvar c = 0; c < NUM_COMP; c++) begin : g_comp
    vpd_ram #(
      .WIDTH(8),
      .DEPTH(PALETTE_DEPTH)
    ) u_ram (
      .clk  (clk),
      .we   (ram_we[c]),
      .waddr(write_address),
      .wdata(ram_wdata[c]),
      .re   (ram_re),
      .raddr(read_address),
      .rdata(ram_q[c])
    );
  end

  always_comb begin
    phase_next          = phase;
    read_address_next   = read_address;
    write_address_next  = write_address;
    in_read_mode_next   = in_read_mode;
    pixel_mask_next     = pixel_mask;
    mask_count_next     = mask_count;
    hidden_control_next = hidden_control;
    rd_phase_next       = rd_phase;
    rd_ok_next          = rd_ok;
    valid_set           = 1'b0;
    ram_re              = 1'b0;
    ram_we              = '0;
    rd_val              = '0;
    changed             = 1'b0;
    hid                 = 1'b0;
    wrote               = 1'b0;
    for (int c = 0; c < NUM_COMP; c++) begin
      staged_next[c] = staged[c];
      ram_wdata[c]   = '0;
    end
    data_m = eight_bit_mode ? write_data : (write_data & COMP_MASK_6BIT);

    if (cmd.accept) begin
      if (action == ACT_WRITE) begin
        case (port_t'(port_select))
          PORT_MASK: begin
            if (vga_class && (mask_count >= UNLOCK_COUNT)) begin
              hidden_control_next = write_data;
              mask_count_next     = '0;
              hid                 = 1'b1;
            end else if (pixel_mask != write_data) begin
              pixel_mask_next = write_data;
              changed         = 1'b1;
            end
          end
          PORT_READ_ADDR: begin
            mask_count_next    = '0;
            phase_next         = PHASE_RED;
            in_read_mode_next  = 1'b1;
            read_address_next  = write_data;
            write_address_next = 8'(write_data + 8'd1);
          end
          PORT_WRITE_ADDR: begin
            mask_count_next    = '0;
            phase_next         = PHASE_RED;
            in_read_mode_next  = 1'b0;
            write_address_next = write_data;
            if (!shared_index_variant) begin
              read_address_next = 8'(write_data - 8'd1);
            end
          end
          default: begin
            mask_count_next = '0;
            if (phase != PHASE_NONE) begin
              staged_next[phase] = data_m;
              if (!full_load_update) begin
                // A first write to an entry also clears its other components.
                for (int c = 0; c < NUM_COMP; c++) begin
                  ram_we[c]    = (phase == 2'(c)) || !entry_valid[write_address];
                  ram_wdata[c] = (phase == 2'(c)) ? data_m : '0;
                end
                wrote = 1'b1;
              end else if (phase == PHASE_BLUE) begin
                ram_we       = '1;
                ram_wdata[0] = staged[0];
                ram_wdata[1] = staged[1];
                ram_wdata[2] = data_m;
                wrote        = 1'b1;
              end
              phase_next = (phase == PHASE_BLUE) ? PHASE_RED : 2'(phase + 2'd1);
              if (wrote) begin
                valid_set = 1'b1;
                changed   = !latched_colour_mode;
                if (phase == PHASE_BLUE) begin
                  read_address_next  = write_address;
                  write_address_next = 8'(write_address + 8'd1);
                end
              end
            end
          end
        endcase
      end else begin
        case (port_t'(port_select))
          PORT_MASK: begin
            if (hidden_reg_enable && (mask_count < UNLOCK_COUNT)) begin
              mask_count_next = 3'(mask_count + 3'd1);
            end
            rd_val = pixel_mask;
          end
          PORT_READ_ADDR: begin
            mask_count_next = '0;
            rd_val          = in_read_mode ? STATUS_READ_MODE : '0;
          end
          PORT_WRITE_ADDR: begin
            mask_count_next = '0;
            rd_val          = write_address;
          end
          default: begin
            mask_count_next = '0;
            rd_phase_next   = phase;
            if (phase != PHASE_NONE) begin
              ram_re     = 1'b1;
              rd_ok_next = entry_valid[read_address];
              if (phase == PHASE_BLUE) begin
                phase_next         = PHASE_RED;
                read_address_next  = write_address;
                write_address_next = 8'(write_address + 8'd1);
              end else begin
                phase_next = 2'(phase + 2'd1);
              end
            end else begin
              rd_ok_next = 1'b0;
            end
          end
        endcase
      end
    end

    case (rd_phase)
      PHASE_RED:   mem_val = ram_q[0];
      PHASE_GREEN: mem_val = ram_q[1];
      PHASE_BLUE:  mem_val = ram_q[2];
      default:     mem_val = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      eight_bit_mode       <= 1'b0;
      hidden_reg_enable    <= 1'b0;
      full_load_update     <= 1'b0;
      shared_index_variant <= 1'b0;
      vga_class            <= 1'b1;
      latched_colour_mode  <= 1'b0;
      for (int c = 0; c < NUM_COMP; c++) begin
        staged[c] <= '0;
      end
      phase          <= PHASE_RED;
      read_address   <= '0;
      write_address  <= '0;
      in_read_mode   <= 1'b1;
      pixel_mask     <= 8'hff;
      mask_count     <= '0;
      hidden_control <= '0;
      rd_phase       <= PHASE_RED;
      rd_ok          <= 1'b0;
      entry_valid    <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_EIGHT_BIT:     eight_bit_mode       <= cfg_data;
          REG_HIDDEN_ENABLE: hidden_reg_enable    <= cfg_data;
          REG_FULL_LOAD:     full_load_update     <= cfg_data;
          REG_SHARED_INDEX:  shared_index_variant <= cfg_data;
          REG_VGA_CLASS:     vga_class            <= cfg_data;
          REG_LATCHED:       latched_colour_mode  <= cfg_data;
          default: ;
        endcase
      end
      for (int c = 0; c < NUM_COMP; c++) begin
        staged[c] <= staged_next[c];
      end
      phase          <= phase_next;
      read_address   <= read_address_next;
      write_address  <= write_address_next;
      in_read_mode   <= in_read_mode_next;
      pixel_mask     <= pixel_mask_next;
      mask_count     <= mask_count_next;
      hidden_control <= hidden_control_next;
      rd_phase       <= rd_phase_next;
      rd_ok          <= rd_ok_next;
      if (valid_set) begin
        entry_valid[write_address] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_direct) begin
      read_data       <= rd_val;
      palette_changed <= changed;
      hidden_written  <= hid;
    end else if (cmd.load_mem) begin
      read_data       <= rd_ok ? mem_val : '0;
      palette_changed <= 1'b0;
      hidden_written  <= 1'b0;
    end
  end

endmodule
